// ===== rtl/rsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the RGB sharpen 3x3 convolution block.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // Field widths of the result item
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int CHAN_W     = 8;
  localparam int WEIGHT_W   = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 2'd2;

  // Reset values and limits
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_WIDTH    = 1024;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd9;
  localparam logic [CHAN_W-1:0]   CHAN_MAX     = 8'd255;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // One window column: three vertically adjacent samples
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
  } in_payload_t;

  typedef struct packed {
    logic [COL_W-1:0]  out_column;
    logic [ROW_W-1:0]  out_row;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              last_of_run;
  } out_payload_t;

endpackage
`default_nettype wire

// ===== rtl/rsc_line_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsc_line_ram #(
  parameter int DEPTH  = rsc_pkg::MAX_WIDTH,
  parameter int DATA_W = 48
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write the store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the store; read data is registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rsc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_cell
// Window cell: holds one column of three samples and hands it on to its
// left neighbor each time the window advances.
// ----------------------------------------------------------------------------
module rsc_cell (
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire rsc_pkg::column_t col_in,
  output rsc_pkg::column_t      col_out
);

  rsc_pkg::column_t col_r;

  // Advance the column
  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule
`default_nettype wire

// ===== rtl/rsc_kernel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_kernel
// 3x3 kernel: centre weight times centre sample minus the eight neighbors,
// per color channel, clamped to 0..255.
// ----------------------------------------------------------------------------
module rsc_kernel (
  input  wire rsc_pkg::column_t                    left_col,
  input  wire rsc_pkg::column_t                    mid_col,
  input  wire rsc_pkg::column_t                    right_col,
  input  wire logic [rsc_pkg::WEIGHT_W-1:0]        center_weight,
  output rsc_pkg::pixel_t                          result
);

  localparam int POS_W = rsc_pkg::WEIGHT_W + rsc_pkg::CHAN_W;
  localparam int NEG_W = rsc_pkg::CHAN_W + 3;

  logic [8:0][2:0][rsc_pkg::CHAN_W-1:0] taps;
  logic [2:0][rsc_pkg::CHAN_W-1:0]      chans;
  logic [POS_W-1:0]                     pos;
  logic [NEG_W-1:0]                     neg;
  logic [POS_W-1:0]                     diff;

  // Arrange the window row by row; centre is tap 4
  assign taps[0] = left_col.top;
  assign taps[1] = mid_col.top;
  assign taps[2] = right_col.top;
  assign taps[3] = left_col.mid;
  assign taps[4] = mid_col.mid;
  assign taps[5] = right_col.mid;
  assign taps[6] = left_col.bot;
  assign taps[7] = mid_col.bot;
  assign taps[8] = right_col.bot;

  // Filter each channel and clamp
  always_comb begin
    chans = '0;
    pos   = '0;
    neg   = '0;
    diff  = '0;
    for (int ch = 0; ch < 3; ch++) begin
      pos = POS_W'(center_weight) * POS_W'(taps[4][ch]);
      neg = '0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4) begin
          neg = neg + NEG_W'(taps[k][ch]);
        end
      end
      if (POS_W'(neg) > pos) begin
        chans[ch] = '0;
      end else begin
        diff = pos - POS_W'(neg);
        if (diff > POS_W'(rsc_pkg::CHAN_MAX)) begin
          chans[ch] = rsc_pkg::CHAN_MAX;
        end else begin
          chans[ch] = diff[rsc_pkg::CHAN_W-1:0];
        end
      end
    end
  end

  assign result = chans;

endmodule
`default_nettype wire

// ===== rtl/rgb_sharpen_convolution_3x3.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_sharpen_convolution_3x3
// 3x3 sharpen / Laplacian filter on an RGB888 raster stream.
//
// Pixels enter on the in_ channel in raster order, one request per pixel.
// Each result on the out_ channel carries its own column and row: border
// pixels pass through unchanged, and an interior pixel comes out once the
// pixel below-right of it has arrived (interior result first, then any
// border passthrough of the same input; last_of_run marks the final one).
// The cfg_ channel writes image width, image height and centre weight;
// cfg_ready is always high. A size write restarts the frame at (0, 0).
// Throughput is one pixel per cycle while out_ready is high; an input that
// yields two results holds in_ready low while the output pair drains.
// From input accept to result valid, the line store read and the pixel
// register load on the accept edge, and the filtered result then loads into
// the output register when the filter stage fires.
// When out_ready is low, results wait in the two-entry output register and
// the pipeline stalls behind them. Reset clears the pipeline, the frame
// position and the registers (640 x 480, weight 9); line store contents
// are not cleared and are never used before being written in a frame.
// ----------------------------------------------------------------------------
module rgb_sharpen_convolution_3x3 #(
  parameter int MAX_WIDTH = rsc_pkg::MAX_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire rsc_pkg::in_payload_t            in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output rsc_pkg::out_payload_t                out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = rsc_pkg::ROW_W;
  localparam int PIX_W   = $bits(rsc_pkg::pixel_t);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int EW      = (WW > rsc_pkg::WIDTH_W) ? WW : rsc_pkg::WIDTH_W;
  localparam int HW      = rsc_pkg::HEIGHT_W;
  localparam int RST_W   = (rsc_pkg::WIDTH_RESET < MAX_WIDTH) ?
                           rsc_pkg::WIDTH_RESET : MAX_WIDTH;
  localparam logic [CW-1:0] LAST_COL_RESET = CW'(RST_W - 1);
  localparam logic [RW-1:0] LAST_ROW_RESET = RW'(rsc_pkg::HEIGHT_RESET - 1);

  // Configuration state
  logic [CW-1:0]                last_col_r;
  logic [RW-1:0]                last_row_r;
  logic [rsc_pkg::WEIGHT_W-1:0] weight_r;
  logic [EW-1:0]                wval;
  logic [HW-1:0]                hval;

  // Frame position
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  // Filter stage
  logic                b_valid_r;
  rsc_pkg::pixel_t     b_px_r;
  logic [CW-1:0]       b_col_r;
  logic [RW-1:0]       b_row_r;
  logic                b_int_r;
  logic                b_bord_r;
  logic                fwd_hit_r;
  logic [2*PIX_W-1:0]  fwd_data_r;
  logic [2*PIX_W-1:0]  rd_data;
  logic [2*PIX_W-1:0]  line_q;
  logic [2*PIX_W-1:0]  wr_data;
  rsc_pkg::pixel_t     top_px;
  rsc_pkg::pixel_t     mid_px;
  rsc_pkg::column_t    new_col;
  rsc_pkg::column_t    win_left;
  rsc_pkg::column_t    win_mid;
  rsc_pkg::pixel_t     filt_px;

  // Output register
  rsc_pkg::out_payload_t slot0_r;
  rsc_pkg::out_payload_t slot1_r;
  logic [1:0]            ocnt_r;
  rsc_pkg::out_payload_t int_res;
  rsc_pkg::out_payload_t bord_res;
  rsc_pkg::out_payload_t e0;

  logic in_acc;
  logic out_acc;
  logic buf_free;
  logic b_fire;
  logic b_has_res;

  assign cfg_ready = 1'b1;

  // Handshakes
  assign out_valid = (ocnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign out_acc   = out_valid && out_ready;
  assign buf_free  = (ocnt_r == 2'd0) || ((ocnt_r == 2'd1) && out_ready);
  assign b_has_res = b_int_r || b_bord_r;
  assign b_fire    = b_valid_r && (!b_has_res || buf_free);
  assign in_ready  = !b_valid_r || b_fire;
  assign in_acc    = in_valid && in_ready;

  // Take the size register values from their data fields
  assign wval = EW'(cfg_data[rsc_pkg::WIDTH_W-1:0]);
  assign hval = cfg_data[HW-1:0];

  // Hold configuration and frame position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= LAST_COL_RESET;
      last_row_r <= LAST_ROW_RESET;
      weight_r   <= rsc_pkg::WEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rsc_pkg::REG_IMAGE_WIDTH: begin
          if (wval == '0) begin
            last_col_r <= '0;
          end else if (wval > EW'(MAX_WIDTH)) begin
            last_col_r <= CW'(MAX_WIDTH - 1);
          end else begin
            last_col_r <= CW'(wval - EW'(1));
          end
          col_r <= '0;
          row_r <= '0;
        end
        rsc_pkg::REG_IMAGE_HEIGHT: begin
          if (hval == '0) begin
            last_row_r <= '0;
          end else if (hval > HW'(rsc_pkg::MAX_HEIGHT)) begin
            last_row_r <= RW'(rsc_pkg::MAX_HEIGHT - 1);
          end else begin
            last_row_r <= RW'(hval - HW'(1));
          end
          col_r <= '0;
          row_r <= '0;
        end
        rsc_pkg::REG_CENTER_WEIGHT: begin
          weight_r <= cfg_data[rsc_pkg::WEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (col_r == last_col_r) begin
        col_r <= '0;
        row_r <= (row_r == last_row_r) ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Advance the accepted pixel into the filter stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_acc) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_px_r     <= in_data;
      b_col_r    <= col_r;
      b_row_r    <= row_r;
      b_int_r    <= (col_r >= CW'(2)) && (row_r >= RW'(2));
      b_bord_r   <= (row_r == '0) || (row_r == last_row_r) ||
                    (col_r == '0) || (col_r == last_col_r);
      // Forward a write to the same entry that lands in this cycle
      fwd_hit_r  <= b_fire && (b_col_r == col_r);
      fwd_data_r <= wr_data;
    end
  end

  // Line stores: upper half older line, lower half previous line
  assign wr_data = {mid_px, b_px_r};

  rsc_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PIX_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (b_fire),
    .wr_addr (b_col_r),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (rd_data)
  );

  assign line_q = fwd_hit_r ? fwd_data_r : rd_data;
  assign top_px = line_q[2*PIX_W-1:PIX_W];
  assign mid_px = line_q[PIX_W-1:0];

  // Window: chain of two column cells
  assign new_col = '{top: top_px, mid: mid_px, bot: b_px_r};

  rsc_cell u_cell_mid (
    .clk      (clk),
    .shift_en (b_fire),
    .col_in   (new_col),
    .col_out  (win_mid)
  );

  rsc_cell u_cell_left (
    .clk      (clk),
    .shift_en (b_fire),
    .col_in   (win_mid),
    .col_out  (win_left)
  );

  rsc_kernel u_kernel (
    .left_col      (win_left),
    .mid_col       (win_mid),
    .right_col     (new_col),
    .center_weight (weight_r),
    .result        (filt_px)
  );

  // Build the results of the filter stage
  always_comb begin
    int_res.out_column  = rsc_pkg::COL_W'(b_col_r - CW'(1));
    int_res.out_row     = b_row_r - RW'(1);
    int_res.out_red     = filt_px.red;
    int_res.out_green   = filt_px.green;
    int_res.out_blue    = filt_px.blue;
    int_res.last_of_run = !b_bord_r;

    bord_res.out_column  = rsc_pkg::COL_W'(b_col_r);
    bord_res.out_row     = b_row_r;
    bord_res.out_red     = b_px_r.red;
    bord_res.out_green   = b_px_r.green;
    bord_res.out_blue    = b_px_r.blue;
    bord_res.last_of_run = 1'b1;

    e0 = b_int_r ? int_res : bord_res;
  end

  // Hold results until taken; drop the shown one on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
    end else if (b_fire && b_has_res) begin
      ocnt_r <= (b_int_r && b_bord_r) ? 2'd2 : 2'd1;
    end else if (out_acc) begin
      ocnt_r <= ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_has_res) begin
      slot0_r <= e0;
      slot1_r <= bord_res;
    end else if (out_acc) begin
      slot0_r <= slot1_r;
    end
  end

endmodule
`default_nettype wire

// ===== sim/sharpen_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_checker
// Watches the pixel, result and register channels of the 3x3 sharpen
// filter, keeps its own copy of the line stores, the window and the frame
// position, predicts the results of every accepted pixel request and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module sharpen_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  rsc_pkg::in_payload_t            in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  rsc_pkg::out_payload_t           out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              err_count,
  output int                              pending
);
  import rsc_pkg::*;

  // Register copies
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [WEIGHT_W-1:0] weight_reg;

  // Two rows above the current one, and the two window columns to the left
  pixel_t  older_row [MAX_WIDTH];
  pixel_t  upper_row [MAX_WIDTH];
  column_t left_col;
  column_t centre_col;
  int      col_pos;
  int      row_pos;

  out_payload_t expected_pixels [$];

  initial begin
    err_count = 0;
    pending   = 0;
  end

  function automatic int active_width();
    int w;
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = int'(height_reg);
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int chan_val(input logic [3*CHAN_W-1:0] p, input int ch);
    return int'(p[ch*CHAN_W +: CHAN_W]);
  endfunction

  function automatic logic [CHAN_W-1:0] clamp_chan(input int sum);
    if (sum < 0) return '0;
    if (sum > int'(CHAN_MAX)) return CHAN_MAX;
    return CHAN_W'(sum);
  endfunction

  // Work out the results of one pixel and advance the frame position
  task automatic predict_pixel(input in_payload_t req);
    int                    w;
    int                    h;
    int                    c;
    int                    r;
    int                    sum;
    bit                    interior;
    bit                    border;
    pixel_t                px;
    pixel_t                top_px;
    pixel_t                mid_px;
    pixel_t                ring [8];
    logic [3*CHAN_W-1:0]   filtered;
    out_payload_t          inner_res;
    out_payload_t          edge_res;
    w = active_width();
    h = active_height();
    c = col_pos;
    r = row_pos;
    px = pixel_t'(req);
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    top_px = older_row[c];
    mid_px = upper_row[c];
    interior = (c >= 2) && (r >= 2);
    border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);

    // Filter the pixel above-left of this one: centre weighted, eight taps at -1
    if (interior) begin
      ring[0] = left_col.top;
      ring[1] = centre_col.top;
      ring[2] = top_px;
      ring[3] = left_col.mid;
      ring[4] = mid_px;
      ring[5] = left_col.bot;
      ring[6] = centre_col.bot;
      ring[7] = px;
      for (int ch = 0; ch < 3; ch++) begin
        sum = int'(weight_reg) * chan_val(centre_col.mid, ch);
        for (int k = 0; k < 8; k++) sum -= chan_val(ring[k], ch);
        filtered[ch*CHAN_W +: CHAN_W] = clamp_chan(sum);
      end
      inner_res.out_column  = COL_W'(c - 1);
      inner_res.out_row     = ROW_W'(r - 1);
      inner_res.out_red     = filtered[2*CHAN_W +: CHAN_W];
      inner_res.out_green   = filtered[CHAN_W +: CHAN_W];
      inner_res.out_blue    = filtered[0 +: CHAN_W];
      inner_res.last_of_run = !border;
      expected_pixels.push_back(inner_res);
    end

    // Pass border pixels through unchanged
    if (border) begin
      edge_res.out_column  = COL_W'(c);
      edge_res.out_row     = ROW_W'(r);
      edge_res.out_red     = px.red;
      edge_res.out_green   = px.green;
      edge_res.out_blue    = px.blue;
      edge_res.last_of_run = 1'b1;
      expected_pixels.push_back(edge_res);
    end

    // Shift the window and update the line stores
    left_col   = centre_col;
    centre_col = '{top: top_px, mid: mid_px, bot: px};
    older_row[c] = mid_px;
    upper_row[c] = px;

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    out_payload_t want;
    if (!rst_n) begin
      width_reg  = WIDTH_W'(WIDTH_RESET);
      height_reg = HEIGHT_W'(HEIGHT_RESET);
      weight_reg = WEIGHT_RESET;
      left_col   = '0;
      centre_col = '0;
      col_pos    = 0;
      row_pos    = 0;
      expected_pixels.delete();
    end else begin
      // Compare results first so a request of this edge cannot mask a stray one
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result at column %0d row %0d with nothing expected",
                 out_data.out_column, out_data.out_row);
          err_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_column", want.out_column, out_data.out_column);
          check_field("out_row", want.out_row, out_data.out_row);
          check_field("out_red", want.out_red, out_data.out_red);
          check_field("out_green", want.out_green, out_data.out_green);
          check_field("out_blue", want.out_blue, out_data.out_blue);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
        end
      end

      // Register writes; a size write restarts the frame
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[WIDTH_W-1:0];
            col_pos   = 0;
            row_pos   = 0;
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[HEIGHT_W-1:0];
            col_pos    = 0;
            row_pos    = 0;
          end
          REG_CENTER_WEIGHT: begin
            weight_reg = cfg_data[WEIGHT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (in_valid && in_ready) predict_pixel(in_data);
    end
    pending <= expected_pixels.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the 3x3 sharpen filter: a directed frame with clamping and
// border cases, size and weight extremes, then random frames and bursts
// under random idling on both channels, one long result stall and pauses
// until the pipeline drains. Checking is done by sharpen_checker.
// ----------------------------------------------------------------------------
module tb;
  import rsc_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_ITEMS  = 210;
  localparam int CYCLE_LIMIT   = 600000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Frame of 4 x 4: clamp high and low, alternating bits, extremes
  localparam logic [3*CHAN_W-1:0] CORNER_FRAME [16] = '{
    24'h000000, 24'hFFFFFF, 24'hAA55AA, 24'h55AA55,
    24'h000000, 24'hFFFFFF, 24'h000000, 24'h123456,
    24'h808080, 24'h010101, 24'hFEFEFE, 24'h7F7F7F,
    24'hFFFFFF, 24'h000000, 24'h0F0F0F, 24'hF0F0F0
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_payload_t            in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_payload_t           out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int   err_count;
  int   pending;
  int   cycle_count = 0;
  int   hold_req;
  logic no_idle;

  rgb_sharpen_convolution_3x3 u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sharpen_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Write one register, then leave the channel idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel request after a random gap; valid stays high when no gap
  task automatic send_pixel(input in_payload_t px);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_payload_t random_pixel();
    logic [3*CHAN_W-1:0] bits;
    case ($urandom_range(0, 7))
      0: bits = '0;
      1: bits = '1;
      2: begin
        for (int ch = 0; ch < 3; ch++) begin
          bits[ch*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? CHAN_MAX : '0;
        end
      end
      default: bits = (3*CHAN_W)'($urandom_range(0, 24'hFFFFFF));
    endcase
    return in_payload_t'(bits);
  endfunction

  function automatic int pick_size(input int hi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, 2);
    return $urandom_range(3, hi);
  endfunction

  // Receiver: random stall per result, plus one long hold-off on request
  initial begin : receiver
    int stall;
    int hold_seen;
    out_ready = 1'b0;
    hold_seen = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int sent;
    int phase;
    int burst;
    int frame_w;
    int frame_h;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    no_idle   = 1'b0;
    hold_req  = 0;
    rst_n     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed 4 x 4 sharpen frame
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_IMAGE_HEIGHT, 4);
    write_reg(REG_CENTER_WEIGHT, 9);
    for (int i = 0; i < 16; i++) send_pixel(in_payload_t'(CORNER_FRAME[i]));
    wait_drained();

    // Narrow frame: every pixel is border; Laplacian weight
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 3);
    write_reg(REG_CENTER_WEIGHT, 8);
    for (int i = 0; i < 6; i++) send_pixel(in_payload_t'(CORNER_FRAME[i + 5]));
    wait_drained();

    // Oversized registers saturate; sweep a full widest row
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_IMAGE_HEIGHT, 8191);
    write_reg(REG_CENTER_WEIGHT, 15);
    for (int i = 0; i < MAX_WIDTH + 6; i++) send_pixel(random_pixel());
    wait_drained();

    // Zero sizes act as one
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_CENTER_WEIGHT, 0);
    for (int i = 0; i < 8; i++) send_pixel(random_pixel());
    wait_drained();

    // Upper data bits beyond the width field are dropped; spare index ignored
    write_reg(REG_IMAGE_WIDTH, 13'h1400);
    write_reg(REG_IMAGE_HEIGHT, MAX_HEIGHT);
    write_reg(REG_SPARE, 13'h1FFF);
    for (int i = 0; i < 20; i++) send_pixel(random_pixel());
    wait_drained();

    // Tall thin frame, many rows deep
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_CENTER_WEIGHT, 9);
    for (int i = 0; i < 60; i++) send_pixel(random_pixel());
    frame_w = 3;
    frame_h = MAX_HEIGHT;

    // Random frames and bursts; a size write also restarts mid-frame
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        wait_drained();
        if (phase == 0 || $urandom_range(0, 2) != 0) begin
          frame_w = pick_size(10);
          write_reg(REG_IMAGE_WIDTH, frame_w);
        end
        if (phase == 0 || $urandom_range(0, 2) != 0) begin
          frame_h = pick_size(8);
          write_reg(REG_IMAGE_HEIGHT, frame_h);
        end
        if ($urandom_range(0, 1) != 0) begin
          write_reg(REG_CENTER_WEIGHT,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(8, 9));
        end
      end
      burst = $urandom_range(4, 2 * frame_w * (frame_h > 8 ? 8 : frame_h) + 4);

      // Stall the receiver long while the sender pushes back to back
      if (phase == 1) begin
        no_idle  <= 1'b1;
        hold_req <= hold_req + 1;
        burst    = 60;
      end else begin
        no_idle <= ($urandom_range(0, 4) == 0);
      end

      for (int i = 0; i < burst; i++) begin
        send_pixel(random_pixel());
        if (phase == 0 && i == burst / 2) wait_drained();
      end
      sent  += burst;
      phase += 1;
    end

    wait_drained();
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
